// ===== sv/lut3d_pkg.sv =====
`timescale 1ns / 1ps
package lut3d_pkg;

  localparam int MAX_LATTICE = 33;
  localparam int ENTRY_W     = 18;
  localparam int SAMPLE_W    = 17;
  localparam int INDEX_W     = 16;
  localparam int SIZE_W      = 6;
  localparam int BASE_W      = 5;
  localparam int FRAC_W      = 17;
  localparam int POS_W       = SAMPLE_W + SIZE_W;
  localparam int STORE_DEPTH = MAX_LATTICE * MAX_LATTICE * MAX_LATTICE;
  localparam int ADDR_W      = 16;
  localparam int LIN0_W      = 11;
  localparam int LINP_W      = 17;
  localparam int SQ_W        = 11;
  localparam int NCORNER     = 8;
  localparam int NCHAN       = 3;
  localparam int WORD_W      = NCHAN * ENTRY_W;
  localparam int DIFF_W      = ENTRY_W + 1;
  localparam int WEIGHT_W    = FRAC_W + 1;
  localparam int PROD_W      = DIFF_W + WEIGHT_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int RND_P_W     = PROD_W - 16;
  localparam int RND_A_W     = ACC_W - 16;
  localparam int RES_W       = 24;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_CNT_W  = 3;
  localparam int BACK_DEPTH  = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 6;

  localparam logic [SAMPLE_W-1:0] ONE_FIX = SAMPLE_W'(65536);

  localparam logic                 CMD_WRITE  = 1'b0;
  localparam logic                 CMD_SAMPLE = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_LUT_SIZE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 1'b1;
  localparam logic                 MODE_TRILINEAR    = 1'b0;
  localparam logic                 MODE_TETRAHEDRAL  = 1'b1;

  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef logic [FRAC_W-1:0]         frac_t;
  typedef logic [BASE_W-1:0]         base_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [RES_W-1:0]   res_t;

  typedef enum logic [2:0] {
    TET_RGB,
    TET_RBG,
    TET_BRG,
    TET_BGR,
    TET_GBR,
    TET_GRB
  } tet_case_e;

  typedef struct packed {
    logic                sample;
    logic [INDEX_W-1:0]  index;
    entry_t              red;
    entry_t              green;
    entry_t              blue;
    base_t               r0;
    base_t               g0;
    base_t               b0;
    frac_t               tr;
    frac_t               tg;
    frac_t               tb;
    tet_case_e           tcase;
  } item_t;

  typedef struct packed {
    logic valid;
    logic sample;
  } ctl_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    return (s > SIZE_W'(MAX_LATTICE)) ? SIZE_W'(MAX_LATTICE) : s;
  endfunction

  function automatic logic signed [RND_P_W-1:0] rnd_prod(input prod_t p);
    prod_t t;
    t = p + PROD_W'(32768);
    return RND_P_W'(t >>> 16);
  endfunction

  function automatic logic signed [RND_A_W-1:0] rnd_acc(input acc_t a);
    acc_t t;
    t = a + ACC_W'(32768);
    return RND_A_W'(t >>> 16);
  endfunction

  function automatic entry_t sat_entry(input res_t v);
    res_t hi;
    res_t lo;
    hi = RES_W'((1 << (ENTRY_W - 1)) - 1);
    lo = -hi - RES_W'(1);
    if (v > hi) return ENTRY_W'(hi);
    if (v < lo) return ENTRY_W'(lo);
    return ENTRY_W'(v);
  endfunction

endpackage

// ===== sv/lut3d_if.sv =====
`timescale 1ns / 1ps
interface lut3d_in_if import lut3d_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic [INDEX_W-1:0]  entry_index;
  entry_t              entry_red;
  entry_t              entry_green;
  entry_t              entry_blue;
  logic [SAMPLE_W-1:0] sample_red;
  logic [SAMPLE_W-1:0] sample_green;
  logic [SAMPLE_W-1:0] sample_blue;

  modport source (output valid, command, entry_index, entry_red, entry_green, entry_blue,
                  sample_red, sample_green, sample_blue, input ready);
  modport sink   (input valid, command, entry_index, entry_red, entry_green, entry_blue,
                  sample_red, sample_green, sample_blue, output ready);
endinterface

interface lut3d_out_if import lut3d_pkg::*; ();
  logic   valid;
  logic   ready;
  entry_t out_red;
  entry_t out_green;
  entry_t out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

// ===== sv/lut3d_ram.sv =====
`timescale 1ns / 1ps
module lut3d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== sv/lut3d_fifo.sv =====
`timescale 1ns / 1ps
module lut3d_fifo import lut3d_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  input  logic  pop_i,
  output item_t head_o,
  output logic  full_o,
  output logic  empty_o
);
  item_t                 buf_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, rptr_q;
  logic [FIFO_CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = buf_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    if (pop_i && !push_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wptr_q] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count mismatch");
endmodule

// ===== sv/lut3d_front.sv =====
`timescale 1ns / 1ps
module lut3d_front import lut3d_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  lut3d_in_if.sink          in_ch,
  input  logic [SIZE_W-1:0] lut_size_i,
  input  logic              full_i,
  output logic              push_o,
  output item_t             item_o
);
  logic                f_valid_q;
  logic                fen;
  logic                cmd_q;
  logic [INDEX_W-1:0]  index_q;
  entry_t              red_q, green_q, blue_q;
  logic [POS_W-1:0]    pos_q [NCHAN];
  logic [SAMPLE_W-1:0] smp [NCHAN];
  logic [SIZE_W-1:0]   eff, sizem1, sizem2;
  logic                zero;
  base_t               base [NCHAN];
  frac_t               frac [NCHAN];
  tet_case_e           tcase;

  assign eff    = eff_size(lut_size_i);
  assign zero   = (lut_size_i < SIZE_W'(2));
  assign sizem1 = zero ? '0 : eff - SIZE_W'(1);
  assign sizem2 = zero ? '0 : eff - SIZE_W'(2);

  assign fen         = !f_valid_q || !full_i;
  assign in_ch.ready = fen;
  assign push_o      = f_valid_q && !full_i;

  assign smp[0] = in_ch.sample_red;
  assign smp[1] = in_ch.sample_green;
  assign smp[2] = in_ch.sample_blue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (fen) begin
      f_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fen && in_ch.valid) begin
      cmd_q   <= in_ch.command;
      index_q <= in_ch.entry_index;
      red_q   <= in_ch.entry_red;
      green_q <= in_ch.entry_green;
      blue_q  <= in_ch.entry_blue;
      for (int i = 0; i < NCHAN; i++) begin
        pos_q[i] <= POS_W'((smp[i] > ONE_FIX) ? ONE_FIX : smp[i]) * POS_W'(sizem1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NCHAN; i++) begin
      if (pos_q[i][POS_W-1:16] > (POS_W-16)'(sizem2)) base[i] = sizem2[BASE_W-1:0];
      else base[i] = pos_q[i][16 +: BASE_W];
      frac[i] = FRAC_W'(pos_q[i] - (POS_W'(base[i]) << 16));
    end
  end

  always_comb begin
    if (frac[0] >= frac[1]) begin
      if (frac[1] >= frac[2])      tcase = TET_RGB;
      else if (frac[0] >= frac[2]) tcase = TET_RBG;
      else                         tcase = TET_BRG;
    end else if (frac[2] >= frac[1]) begin
      tcase = TET_BGR;
    end else if (frac[2] >= frac[0]) begin
      tcase = TET_GBR;
    end else begin
      tcase = TET_GRB;
    end
  end

  always_comb begin
    item_o.sample = (cmd_q == CMD_SAMPLE);
    item_o.index  = index_q;
    item_o.red    = red_q;
    item_o.green  = green_q;
    item_o.blue   = blue_q;
    item_o.r0     = base[0];
    item_o.g0     = base[1];
    item_o.b0     = base[2];
    item_o.tr     = frac[0];
    item_o.tg     = frac[1];
    item_o.tb     = frac[2];
    item_o.tcase  = tcase;
  end
endmodule

// ===== sv/lut3d_interp.sv =====
`timescale 1ns / 1ps
module lut3d_interp import lut3d_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  entry_t    c_i [NCORNER],
  input  frac_t     tr_i,
  input  frac_t     tg_i,
  input  frac_t     tb_i,
  input  tet_case_e tcase_i,
  input  logic      zero_i,
  input  logic      mode_i,
  output entry_t    res_o
);
  prod_t  p1_q [4];
  entry_t a1_q [4];
  prod_t  q_q [3];
  entry_t c0_q, c0_2_q;
  frac_t  tg_q [2];
  frac_t  tb_q [4];
  entry_t e_q [4];
  acc_t   acc_q;
  prod_t  pf_q [2];
  entry_t ea_q [2];
  res_t   tet3_q, tet4_q, tet5_q;
  entry_t f_q [2];
  prod_t  pb_q;
  entry_t f0_5_q;
  entry_t res_q;

  entry_t               tp1, tp2;
  logic signed [WEIGHT_W-1:0] w1, w2, w3, wr, wg, wb;
  res_t                 tri_res;

  assign wr = $signed({1'b0, tr_i});
  assign wg = $signed({1'b0, tg_i});
  assign wb = $signed({1'b0, tb_i});

  always_comb begin
    unique case (tcase_i)
      TET_RGB: begin tp1 = c_i[1]; tp2 = c_i[3]; w1 = wr; w2 = wg; w3 = wb; end
      TET_RBG: begin tp1 = c_i[1]; tp2 = c_i[5]; w1 = wr; w2 = wb; w3 = wg; end
      TET_BRG: begin tp1 = c_i[4]; tp2 = c_i[5]; w1 = wb; w2 = wr; w3 = wg; end
      TET_BGR: begin tp1 = c_i[4]; tp2 = c_i[6]; w1 = wb; w2 = wg; w3 = wr; end
      TET_GBR: begin tp1 = c_i[2]; tp2 = c_i[6]; w1 = wg; w2 = wb; w3 = wr; end
      TET_GRB: begin tp1 = c_i[2]; tp2 = c_i[3]; w1 = wg; w2 = wr; w3 = wb; end
      default: begin tp1 = c_i[0]; tp2 = c_i[0]; w1 = '0; w2 = '0; w3 = '0; end
    endcase
  end

  assign tri_res = RES_W'(f0_5_q) + RES_W'(rnd_prod(pb_q));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // corner fetch -> products
      for (int j = 0; j < 4; j++) begin
        p1_q[j] <= (DIFF_W'(c_i[2*j+1]) - DIFF_W'(c_i[2*j])) * wr;
        a1_q[j] <= c_i[2*j];
      end
      q_q[0] <= (DIFF_W'(tp1) - DIFF_W'(c_i[0])) * w1;
      q_q[1] <= (DIFF_W'(tp2) - DIFF_W'(tp1)) * w2;
      q_q[2] <= (DIFF_W'(c_i[7]) - DIFF_W'(tp2)) * w3;
      c0_q   <= c_i[0];
      tg_q[0] <= tg_i;
      tg_q[1] <= tg_q[0];
      tb_q[0] <= tb_i;
      for (int k = 1; k < 4; k++) tb_q[k] <= tb_q[k-1];
      // red lerps, tetrahedral sum
      for (int j = 0; j < 4; j++) begin
        e_q[j] <= ENTRY_W'(RND_P_W'(a1_q[j]) + rnd_prod(p1_q[j]));
      end
      acc_q  <= ACC_W'(q_q[0]) + ACC_W'(q_q[1]) + ACC_W'(q_q[2]);
      c0_2_q <= c0_q;
      // green products
      pf_q[0] <= (DIFF_W'(e_q[1]) - DIFF_W'(e_q[0])) * $signed({1'b0, tg_q[1]});
      pf_q[1] <= (DIFF_W'(e_q[3]) - DIFF_W'(e_q[2])) * $signed({1'b0, tg_q[1]});
      ea_q[0] <= e_q[0];
      ea_q[1] <= e_q[2];
      tet3_q  <= RES_W'(c0_2_q) + RES_W'(rnd_acc(acc_q));
      // green lerps
      f_q[0] <= ENTRY_W'(RND_P_W'(ea_q[0]) + rnd_prod(pf_q[0]));
      f_q[1] <= ENTRY_W'(RND_P_W'(ea_q[1]) + rnd_prod(pf_q[1]));
      tet4_q <= tet3_q;
      // blue product
      pb_q   <= (DIFF_W'(f_q[1]) - DIFF_W'(f_q[0])) * $signed({1'b0, tb_q[3]});
      f0_5_q <= f_q[0];
      tet5_q <= tet4_q;
      // result
      if (zero_i) res_q <= '0;
      else if (mode_i == MODE_TRILINEAR) res_q <= sat_entry(tri_res);
      else res_q <= sat_entry(tet5_q);
    end
  end

  assign res_o = res_q;
endmodule

// ===== sv/lut3d_back.sv =====
`timescale 1ns / 1ps
module lut3d_back import lut3d_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  item_t             head_i,
  output logic              pop_o,
  input  logic [SIZE_W-1:0] lut_size_i,
  input  logic              interp_mode_i,
  lut3d_out_if.source       out_ch
);
  ctl_t               ctl_q [BACK_DEPTH];
  logic               en;
  item_t              b0_q, b1_q, b2_q;
  logic [LIN0_W-1:0]  lin0_q;
  logic [ADDR_W-1:0]  lin_q;
  logic [SIZE_W-1:0]  eff;
  logic [SQ_W-1:0]    sq;
  logic               zero;
  logic [LINP_W-1:0]  linp;
  logic [ADDR_W-1:0]  raddr [NCORNER];
  logic [WORD_W-1:0]  rdata [NCORNER];
  logic [WORD_W-1:0]  wdata;
  logic               we, re;
  entry_t             corner [NCHAN][NCORNER];
  entry_t             res [NCHAN];

  assign eff  = eff_size(lut_size_i);
  assign sq   = SQ_W'(SQ_W'(eff) * SQ_W'(eff));
  assign zero = (lut_size_i < SIZE_W'(2));

  assign out_ch.valid = ctl_q[BACK_DEPTH-1].valid && ctl_q[BACK_DEPTH-1].sample;
  assign en           = !out_ch.valid || out_ch.ready;
  assign pop_o        = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BACK_DEPTH; i++) ctl_q[i] <= '0;
    end else if (en) begin
      ctl_q[0].valid  <= !empty_i;
      ctl_q[0].sample <= head_i.sample;
      for (int i = 1; i < BACK_DEPTH; i++) ctl_q[i] <= ctl_q[i-1];
    end
  end

  assign linp = LINP_W'(lin0_q) * LINP_W'(eff) + LINP_W'(b0_q.r0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_q   <= head_i;
      lin0_q <= LIN0_W'(head_i.b0) * LIN0_W'(eff) + LIN0_W'(head_i.g0);
      b1_q   <= b0_q;
      lin_q  <= b0_q.sample ? linp[ADDR_W-1:0] : b0_q.index;
      b2_q   <= b1_q;
    end
  end

  always_comb begin
    for (int k = 0; k < NCORNER; k++) begin
      raddr[k] = lin_q + ADDR_W'(k % 2)
               + (((k / 2) % 2 == 1) ? ADDR_W'(eff) : '0)
               + ((k / 4 == 1) ? ADDR_W'(sq) : '0);
    end
  end

  assign we    = en && ctl_q[1].valid && !ctl_q[1].sample
                 && (lin_q < ADDR_W'(STORE_DEPTH));
  assign re    = en && ctl_q[1].valid && ctl_q[1].sample;
  assign wdata = {b1_q.blue, b1_q.green, b1_q.red};

  for (genvar k = 0; k < NCORNER; k++) begin : g_bank
    lut3d_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (lin_q),
      .wdata_i (wdata),
      .re_i    (re),
      .raddr_i (raddr[k]),
      .rdata_o (rdata[k])
    );
  end

  always_comb begin
    for (int c = 0; c < NCHAN; c++) begin
      for (int k = 0; k < NCORNER; k++) begin
        corner[c][k] = rdata[k][c*ENTRY_W +: ENTRY_W];
      end
    end
  end

  for (genvar c = 0; c < NCHAN; c++) begin : g_chan
    lut3d_interp u_interp (
      .clk_i   (clk_i),
      .en_i    (en),
      .c_i     (corner[c]),
      .tr_i    (b2_q.tr),
      .tg_i    (b2_q.tg),
      .tb_i    (b2_q.tb),
      .tcase_i (b2_q.tcase),
      .zero_i  (zero),
      .mode_i  (interp_mode_i),
      .res_o   (res[c])
    );
  end

  assign out_ch.out_red   = res[0];
  assign out_ch.out_green = res[1];
  assign out_ch.out_blue  = res[2];
endmodule

// ===== sv/lut3d_color_interpolator_top.sv =====
`timescale 1ns / 1ps
// 3D color LUT with trilinear or tetrahedral interpolation. Input transfers either write one
// lattice entry (linear index, red fastest) or sample an RGB color; each sample yields one
// saturated RGB result, writes yield none. Throughput is one transfer per clock while the
// output is taken: the lattice is held in eight copies, one per cell corner, each written on
// every lattice write and read at one address per cycle. Samples pass through one front
// stage, the decoupling queue and nine back stages (index multiplies, memory read, six
// interpolation stages). Lattice entries are undefined until written; there is no clearing
// pass. Change lut_size or interp_mode only while the block is idle.
module lut3d_color_interpolator_top import lut3d_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  lut3d_in_if.sink              in_ch_i,
  lut3d_out_if.source           out_ch_o
);
  logic [SIZE_W-1:0] lut_size_q;
  logic              interp_mode_q;
  logic              push, pop, full, empty;
  item_t             f_item, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lut_size_q    <= SIZE_W'(MAX_LATTICE);
      interp_mode_q <= MODE_TETRAHEDRAL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LUT_SIZE:    lut_size_q    <= cfg_data_i[SIZE_W-1:0];
        REG_INTERP_MODE: interp_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  lut3d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch_i),
    .lut_size_i (lut_size_q),
    .full_i     (full),
    .push_o     (push),
    .item_o     (f_item)
  );

  lut3d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_item),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  lut3d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .lut_size_i    (lut_size_q),
    .interp_mode_i (interp_mode_q),
    .out_ch        (out_ch_o)
  );
endmodule

// ===== verif/tb_lut3d_color_interpolator_top.sv =====
`timescale 1ns / 1ps
module tb_lut3d_color_interpolator_top;
  import lut3d_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    entry_t red;
    entry_t green;
    entry_t blue;
  } rgb_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lut3d_in_if  in_ch();
  lut3d_out_if out_ch();

  lut3d_color_interpolator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch_i    (in_ch),
    .out_ch_o   (out_ch)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  int   lattice [STORE_DEPTH][NCHAN];
  bit   entry_written [STORE_DEPTH];
  int   size_reg = 33;
  bit   mode_reg = MODE_TETRAHEDRAL;
  rgb_t expected_rgb_q [$];

  bit   src_idle_en = 1'b1;
  bit   snk_idle_en = 1'b1;
  int   hold_cycles = 0;
  int   errors = 0;
  int   n_writes = 0;
  int   n_samples = 0;
  int   n_checked = 0;
  int   idle_count = 0;

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_WRITE;
    in_ch.entry_index  = '0;
    in_ch.entry_red    = '0;
    in_ch.entry_green  = '0;
    in_ch.entry_blue   = '0;
    in_ch.sample_red   = '0;
    in_ch.sample_green = '0;
    in_ch.sample_blue  = '0;
    out_ch.ready       = 1'b0;
  end

  function automatic int eff_lut_size();
    return (size_reg > MAX_LATTICE) ? MAX_LATTICE : size_reg;
  endfunction

  function automatic void split_coord(input logic [SAMPLE_W-1:0] s, input int sz,
                                      output int base, output longint frac);
    longint c;
    longint pos;
    c = (s > 65536) ? 65536 : s;
    pos = c * (sz - 1);
    base = int'(pos >>> 16);
    if (base > sz - 2) base = sz - 2;
    frac = pos - (longint'(base) <<< 16);
  endfunction

  function automatic longint round_half_up(input longint x);
    return (x + 32768) >>> 16;
  endfunction

  function automatic longint lerp(input longint a, input longint b, input longint t);
    return a + round_half_up((b - a) * t);
  endfunction

  function automatic entry_t saturate(input longint v);
    longint hi;
    hi = (longint'(1) <<< (ENTRY_W - 1)) - 1;
    if (v > hi) return entry_t'(hi);
    if (v < -hi - 1) return entry_t'(-hi - 1);
    return entry_t'(v);
  endfunction

  function automatic int lattice_addr(input int sz, input int r, input int g, input int b);
    return (b * sz + g) * sz + r;
  endfunction

  function automatic rgb_t interpolate_color(input logic [SAMPLE_W-1:0] sr,
                                             input logic [SAMPLE_W-1:0] sg,
                                             input logic [SAMPLE_W-1:0] sb);
    rgb_t   res;
    int     sz, r0, g0, b0;
    longint tr, tg, tb;
    longint c[2][2][2];
    longint v, acc, e00, e10, e01, e11, f0, f1;
    entry_t outv[NCHAN];
    sz = eff_lut_size();
    if (size_reg < 2) begin
      res.red = '0; res.green = '0; res.blue = '0;
      return res;
    end
    split_coord(sr, sz, r0, tr);
    split_coord(sg, sz, g0, tg);
    split_coord(sb, sz, b0, tb);
    for (int ch = 0; ch < NCHAN; ch++) begin
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          for (int k = 0; k < 2; k++)
            c[i][j][k] = lattice[lattice_addr(sz, r0 + i, g0 + j, b0 + k)][ch];
      if (mode_reg == MODE_TRILINEAR) begin
        e00 = lerp(c[0][0][0], c[1][0][0], tr);
        e10 = lerp(c[0][1][0], c[1][1][0], tr);
        e01 = lerp(c[0][0][1], c[1][0][1], tr);
        e11 = lerp(c[0][1][1], c[1][1][1], tr);
        f0 = lerp(e00, e10, tg);
        f1 = lerp(e01, e11, tg);
        v = lerp(f0, f1, tb);
      end else begin
        if (tr >= tg) begin
          if (tg >= tb)
            acc = (c[1][0][0] - c[0][0][0]) * tr + (c[1][1][0] - c[1][0][0]) * tg
                + (c[1][1][1] - c[1][1][0]) * tb;
          else if (tr >= tb)
            acc = (c[1][0][0] - c[0][0][0]) * tr + (c[1][0][1] - c[1][0][0]) * tb
                + (c[1][1][1] - c[1][0][1]) * tg;
          else
            acc = (c[0][0][1] - c[0][0][0]) * tb + (c[1][0][1] - c[0][0][1]) * tr
                + (c[1][1][1] - c[1][0][1]) * tg;
        end else if (tb >= tg) begin
          acc = (c[0][0][1] - c[0][0][0]) * tb + (c[0][1][1] - c[0][0][1]) * tg
              + (c[1][1][1] - c[0][1][1]) * tr;
        end else if (tb >= tr) begin
          acc = (c[0][1][0] - c[0][0][0]) * tg + (c[0][1][1] - c[0][1][0]) * tb
              + (c[1][1][1] - c[0][1][1]) * tr;
        end else begin
          acc = (c[0][1][0] - c[0][0][0]) * tg + (c[1][1][0] - c[0][1][0]) * tr
              + (c[1][1][1] - c[1][1][0]) * tb;
        end
        v = c[0][0][0] + round_half_up(acc);
      end
      outv[ch] = saturate(v);
    end
    res.red = outv[0]; res.green = outv[1]; res.blue = outv[2];
    return res;
  endfunction

  // sender: one transfer per call, prediction at acceptance
  task automatic send_item(input logic cmd, input int idx, input entry_t er, input entry_t eg,
                           input entry_t eb, input logic [SAMPLE_W-1:0] sr,
                           input logic [SAMPLE_W-1:0] sg, input logic [SAMPLE_W-1:0] sb);
    while (src_idle_en && $urandom_range(99) < 37) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.entry_index  <= idx[INDEX_W-1:0];
    in_ch.entry_red    <= er;
    in_ch.entry_green  <= eg;
    in_ch.entry_blue   <= eb;
    in_ch.sample_red   <= sr;
    in_ch.sample_green <= sg;
    in_ch.sample_blue  <= sb;
    do @(posedge clk_i); while (!in_ch.ready);
    if (cmd == CMD_WRITE) begin
      n_writes++;
      if (idx < STORE_DEPTH) begin
        lattice[idx][0] = er;
        lattice[idx][1] = eg;
        lattice[idx][2] = eb;
        entry_written[idx] = 1'b1;
      end
    end else begin
      n_samples++;
      expected_rgb_q.push_back(interpolate_color(sr, sg, sb));
    end
  endtask

  task automatic write_entry(input int idx, input entry_t er, input entry_t eg, input entry_t eb);
    send_item(CMD_WRITE, idx, er, eg, eb, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
              SAMPLE_W'($urandom));
  endtask

  // fills any cell corner not yet written, then samples
  task automatic sample_color(input logic [SAMPLE_W-1:0] sr, input logic [SAMPLE_W-1:0] sg,
                              input logic [SAMPLE_W-1:0] sb);
    int     sz, r0, g0, b0, a;
    longint t;
    if (size_reg >= 2) begin
      sz = eff_lut_size();
      split_coord(sr, sz, r0, t);
      split_coord(sg, sz, g0, t);
      split_coord(sb, sz, b0, t);
      for (int n = 0; n < NCORNER; n++) begin
        a = lattice_addr(sz, r0 + n[0], g0 + n[1], b0 + n[2]);
        if (!entry_written[a])
          write_entry(a, entry_t'($urandom), entry_t'($urandom), entry_t'($urandom));
      end
    end
    send_item(CMD_SAMPLE, $urandom_range(65535), entry_t'($urandom), entry_t'($urandom),
              entry_t'($urandom), sr, sg, sb);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_rgb_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_LUT_SIZE) size_reg = val & 63;
    else mode_reg = val[0];
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_coord();
    case ($urandom_range(9))
      0: return '0;
      1: return SAMPLE_W'(65536);
      2: return SAMPLE_W'($urandom);
      default: return SAMPLE_W'($urandom_range(65536));
    endcase
  endfunction

  function automatic entry_t rand_entry();
    case ($urandom_range(7))
      0: return entry_t'(131071);
      1: return entry_t'(-131072);
      default: return entry_t'($urandom);
    endcase
  endfunction

  // receiver and result check
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        n_checked++;
        if (expected_rgb_q.size() == 0) begin
          $error("unexpected result transfer red=%0d green=%0d blue=%0d",
                 out_ch.out_red, out_ch.out_green, out_ch.out_blue);
          errors++;
        end else begin
          rgb_t e;
          e = expected_rgb_q.pop_front();
          if (out_ch.out_red !== e.red) begin
            $error("out_red expected %0d actual %0d", e.red, out_ch.out_red);
            errors++;
          end
          if (out_ch.out_green !== e.green) begin
            $error("out_green expected %0d actual %0d", e.green, out_ch.out_green);
            errors++;
          end
          if (out_ch.out_blue !== e.blue) begin
            $error("out_blue expected %0d actual %0d", e.blue, out_ch.out_blue);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(snk_idle_en && $urandom_range(99) < 37);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic test_reset_config();
    logic [SAMPLE_W-1:0] edges[4];
    edges = '{17'd0, 17'd65535, 17'd65536, 17'h1FFFF};
    foreach (edges[i]) sample_color(edges[i], edges[3 - i], edges[i]);
    sample_color(17'd32768, 17'd2048, 17'd63000);
  endtask

  task automatic test_tetra_cases();
    logic [SAMPLE_W-1:0] p[13][3];
    p = '{'{17'd30000, 17'd20000, 17'd10000}, '{17'd30000, 17'd10000, 17'd20000},
          '{17'd20000, 17'd10000, 17'd30000}, '{17'd10000, 17'd20000, 17'd30000},
          '{17'd10000, 17'd30000, 17'd20000}, '{17'd20000, 17'd30000, 17'd10000},
          '{17'd20000, 17'd20000, 17'd20000}, '{17'd20000, 17'd20000, 17'd10000},
          '{17'd20000, 17'd10000, 17'd10000}, '{17'd10000, 17'd20000, 17'd20000},
          '{17'd20000, 17'd10000, 17'd20000}, '{17'd0, 17'd0, 17'd0},
          '{17'd65536, 17'd65536, 17'd65536}};
    write_reg(REG_LUT_SIZE, 2);
    for (int a = 0; a < NCORNER; a++)
      write_entry(a, (a % 2) ? entry_t'(131071) : entry_t'(-131072),
                  entry_t'($urandom), (a == 7) ? entry_t'(131071) : entry_t'(-5));
    write_entry(65535, '0, '0, '0);
    write_entry(STORE_DEPTH, '0, '0, '0);
    foreach (p[i]) sample_color(p[i][0], p[i][1], p[i][2]);
    write_reg(REG_INTERP_MODE, MODE_TRILINEAR);
    foreach (p[i]) sample_color(p[i][0], p[i][1], p[i][2]);
  endtask

  task automatic test_degenerate_size();
    write_reg(REG_LUT_SIZE, 0);
    sample_color(17'd40000, 17'd1, 17'd65536);
    write_reg(REG_LUT_SIZE, 1);
    sample_color(17'h1FFFF, 17'd0, 17'd777);
  endtask

  task automatic test_random(input int sz, input bit mode, input int n);
    int lim;
    write_reg(REG_LUT_SIZE, sz);
    write_reg(REG_INTERP_MODE, mode);
    lim = eff_lut_size();
    lim = lim * lim * lim;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: write_entry($urandom_range(lim - 1), rand_entry(), rand_entry(), rand_entry());
        1: write_entry($urandom_range(65535), rand_entry(), rand_entry(), rand_entry());
        default: sample_color(rand_coord(), rand_coord(), rand_coord());
      endcase
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_cycles = 400;
    for (int i = 0; i < 60; i++) sample_color(rand_coord(), rand_coord(), rand_coord());
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_tetra_cases();
    test_degenerate_size();
    test_random(2, MODE_TETRAHEDRAL, 150);
    test_random(3, MODE_TRILINEAR, 150);
    test_random(5, MODE_TETRAHEDRAL, 150);
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    test_random(4, MODE_TRILINEAR, 200);
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    test_backpressure();
    test_random(33, MODE_TETRAHEDRAL, 20);
    test_random(33, MODE_TRILINEAR, 15);
    test_random(63, MODE_TETRAHEDRAL, 10);
    test_random(6, MODE_TRILINEAR, 150);
    test_degenerate_size();
    wait_idle();
    repeat (30) @(posedge clk_i);
    $display("Covered %0d lattice writes and %0d samples, %0d results checked,", n_writes,
             n_samples, n_checked);
    $display("lattice sizes 0 to 63, both interpolation modes, stalls on both sides.");
    if (errors == 0 && expected_rgb_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
